FILE: hdl/sled_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sled_pkg;

  localparam int DUTY_BITS  = 8;
  localparam int DUTY_SHIFT = DUTY_BITS - 3;
  localparam int TIME_BITS  = 32;

  localparam logic [DUTY_BITS-1:0] DUTY_FULL = {DUTY_BITS{1'b1}};

  typedef logic [2:0] pattern_t;
  localparam pattern_t PAT_OFF     = 3'd0;
  localparam pattern_t PAT_START   = 3'd1;
  localparam pattern_t PAT_RUN     = 3'd2;
  localparam pattern_t PAT_COOL    = 3'd3;
  localparam pattern_t PAT_SUSPEND = 3'd4;
  localparam pattern_t PAT_NONE    = 3'd7;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_DISABLED = 2'd0;
  localparam mode_t MODE_STATUS   = 2'd1;
  localparam mode_t MODE_USER     = 2'd2;

  typedef logic [2:0] reg_index_t;
  localparam reg_index_t REG_OUT_MODE        = 3'd0;
  localparam reg_index_t REG_PINS_PRESENT    = 3'd1;
  localparam reg_index_t REG_BREATH_INTERVAL = 3'd2;
  localparam reg_index_t REG_FLASH_ON_TIME   = 3'd3;
  localparam reg_index_t REG_FLASH_PERIOD    = 3'd4;

  localparam logic [9:0]  BREATH_INTERVAL_RESET = 10'd45;
  localparam logic [15:0] FLASH_ON_TIME_RESET   = 16'd50;
  localparam logic [15:0] FLASH_PERIOD_RESET    = 16'd2000;

  typedef struct packed {
    logic                 pwm_attached;
    logic [DUTY_BITS-1:0] pwm_duty;
    logic                 pin1_level;
    logic                 pin2_level;
  } result_t;

  function automatic pattern_t pattern_of(input logic [3:0] rs);
    pattern_t p;
    p = PAT_OFF;
    unique case (rs)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd9:    p = PAT_START;
      4'd5:                            p = PAT_RUN;
      4'd6, 4'd7, 4'd8, 4'd11, 4'd12:  p = PAT_COOL;
      4'd10:                           p = PAT_SUSPEND;
      default:                         p = PAT_OFF;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/status_led_breathe_driver_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Status LED driver: each input transfer (millisecond timestamp, heater run state, user
// bits) updates the pattern state and yields one set of pin outputs. One transfer per
// cycle is sustained while out_stall stays low; each result is registered in out_reg
// after the pattern and deadline logic. A two-entry output buffer
// lets one more input be taken while a result waits; in_stall rises only when both
// entries are full. Configuration writes take effect at once and are meant to be made
// while no transfer is in flight.
module status_led_breathe_driver_core
  import sled_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [TIME_BITS-1:0] now_ms,
  input  wire logic [3:0]           run_state,
  input  wire logic [1:0]           user_bits,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      pwm_attached,
  output logic [DUTY_BITS-1:0]      pwm_duty,
  output logic                      pin1_level,
  output logic                      pin2_level
);

  mode_t       out_mode;
  logic [1:0]  pins_present;
  logic [9:0]  breath_interval;
  logic [15:0] flash_on_time;
  logic [15:0] flash_period;

  pattern_t             last_pattern, last_pattern_next;
  logic [DUTY_BITS-1:0] phase_count, phase_count_next;
  logic [TIME_BITS-1:0] next_deadline, next_deadline_next;
  logic                 pwm_on, pwm_on_next;
  logic                 level_one, level_one_next;
  logic                 level_two, level_two_next;

  result_t result_next;
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  logic                 in_fire;
  logic                 out_fire;
  pattern_t             pat;
  logic                 due;
  logic [TIME_BITS-1:0] flash_gap;
  logic [TIME_BITS-1:0] breath_step;
  logic [TIME_BITS-1:0] deadline_diff;
  logic [DUTY_BITS-1:0] duty_inc;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_fire = out_valid && !out_stall;

  assign flash_gap   = {16'd0, flash_period} - {16'd0, flash_on_time};
  assign breath_step = {{(TIME_BITS-10){1'b0}}, breath_interval};

  always_comb begin
    last_pattern_next  = last_pattern;
    phase_count_next   = phase_count;
    next_deadline_next = next_deadline;
    pwm_on_next        = pwm_on;
    level_one_next     = level_one;
    level_two_next     = level_two;
    pat                = pattern_of(run_state);
    due                = 1'b0;
    deadline_diff      = '0;
    duty_inc           = '0;

    if (out_mode == MODE_STATUS && pins_present[0]) begin
      if (last_pattern != pat) begin
        last_pattern_next = pat;
        phase_count_next  = '0;
        unique case (pat)
          PAT_START: begin
            pwm_on_next        = 1'b1;
            next_deadline_next = now_ms + breath_step;
          end
          PAT_RUN: begin
            pwm_on_next    = 1'b0;
            level_one_next = 1'b1;
          end
          PAT_COOL: begin
            pwm_on_next        = 1'b1;
            phase_count_next   = DUTY_FULL;
            next_deadline_next = now_ms + breath_step;
          end
          PAT_SUSPEND: begin
            pwm_on_next        = 1'b0;
            level_one_next     = 1'b0;
            next_deadline_next = next_deadline + flash_gap;
          end
          default: begin
            pwm_on_next    = 1'b0;
            level_one_next = 1'b0;
          end
        endcase
      end

      deadline_diff = now_ms - next_deadline_next;
      due           = !deadline_diff[TIME_BITS-1];
      duty_inc      = (phase_count_next >> DUTY_SHIFT) + DUTY_BITS'(1);

      if (due) begin
        unique case (pat)
          PAT_START: begin
            next_deadline_next = next_deadline_next + breath_step;
            phase_count_next   = phase_count_next + duty_inc;
          end
          PAT_COOL: begin
            next_deadline_next = next_deadline_next + breath_step;
            phase_count_next   = phase_count_next - duty_inc;
          end
          PAT_SUSPEND: begin
            phase_count_next = phase_count_next + DUTY_BITS'(1);
            if (phase_count_next[0]) begin
              next_deadline_next = next_deadline_next + {16'd0, flash_on_time};
              level_one_next     = 1'b1;
            end else begin
              next_deadline_next = next_deadline_next + flash_gap;
              level_one_next     = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end else if (out_mode == MODE_USER) begin
      if (pins_present[0]) begin
        level_one_next = user_bits[0];
      end
      if (pins_present[1]) begin
        level_two_next = user_bits[1];
      end
    end

    result_next.pwm_attached = pwm_on_next;
    result_next.pwm_duty     = pwm_on_next ? phase_count_next : '0;
    result_next.pin1_level   = !pwm_on_next && level_one_next;
    result_next.pin2_level   = level_two_next;
  end

  // configuration and pattern state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_mode        <= MODE_DISABLED;
      pins_present    <= '0;
      breath_interval <= BREATH_INTERVAL_RESET;
      flash_on_time   <= FLASH_ON_TIME_RESET;
      flash_period    <= FLASH_PERIOD_RESET;
      last_pattern    <= PAT_NONE;
      phase_count     <= '0;
      next_deadline   <= '0;
      pwm_on          <= 1'b0;
      level_one       <= 1'b0;
      level_two       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUT_MODE: begin
          out_mode     <= cfg_data[1:0];
          last_pattern <= PAT_NONE;
          pwm_on       <= 1'b0;
        end
        REG_PINS_PRESENT:    pins_present    <= cfg_data[1:0];
        REG_BREATH_INTERVAL: breath_interval <= cfg_data[9:0];
        REG_FLASH_ON_TIME:   flash_on_time   <= cfg_data;
        REG_FLASH_PERIOD:    flash_period    <= cfg_data;
        default: ;
      endcase
    end else if (in_fire) begin
      last_pattern  <= last_pattern_next;
      phase_count   <= phase_count_next;
      next_deadline <= next_deadline_next;
      pwm_on        <= pwm_on_next;
      level_one     <= level_one_next;
      level_two     <= level_two_next;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (in_fire) begin
        out_reg <= result_next;
      end
    end else if (in_fire) begin
      skid_reg <= result_next;
    end
  end

  assign pwm_attached = out_reg.pwm_attached;
  assign pwm_duty     = out_reg.pwm_duty;
  assign pin1_level   = out_reg.pin1_level;
  assign pin2_level   = out_reg.pin2_level;

endmodule

`default_nettype wire

FILE: sim/status_led_breathe_driver_core_tb.sv
`timescale 1ns / 1ps

module status_led_breathe_driver_core_tb;
  import sled_pkg::*;

  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int    EXP_DEPTH   = 2048;
  localparam int    PLAN_DEPTH  = 64;

  typedef struct {
    logic       is_cfg;
    reg_index_t idx;
    logic [15:0] val;
    logic [31:0] t;
    logic [3:0]  rs;
    logic [1:0]  ub;
    logic        typed;
    result_t     want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [2:0]           cfg_index;
  logic [15:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [TIME_BITS-1:0] now_ms;
  logic [3:0]           run_state;
  logic [1:0]           user_bits;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 pwm_attached;
  logic [DUTY_BITS-1:0] pwm_duty;
  logic                 pin1_level;
  logic                 pin2_level;

  status_led_breathe_driver_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .now_ms(now_ms), .run_state(run_state), .user_bits(user_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .pwm_attached(pwm_attached), .pwm_duty(pwm_duty),
    .pin1_level(pin1_level), .pin2_level(pin2_level)
  );

  // predictor state
  mode_t                led_mode;
  logic [1:0]           led_pins;
  logic [9:0]           breath_ms;
  logic [15:0]          flash_on_ms;
  logic [15:0]          flash_period_ms;
  pattern_t             cur_pattern;
  logic [DUTY_BITS-1:0] duty_phase;
  logic [31:0]          due_ms;
  logic                 pwm_drive;
  logic                 lvl_one;
  logic                 lvl_two;

  result_t exp_pins[0:EXP_DEPTH-1];
  int      exp_head = 0;
  int      exp_tail = 0;
  row_t    plan[0:PLAN_DEPTH-1];
  int      plan_len = 0;
  int      fail_count = 0;
  int      burst_left = 0;
  int      stall_style = 0;
  int      stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic pattern_t classify_state(input logic [3:0] rs);
    case (rs)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd9: return PAT_START;
      4'd5: return PAT_RUN;
      4'd6, 4'd7, 4'd8, 4'd11, 4'd12: return PAT_COOL;
      4'd10: return PAT_SUSPEND;
      default: return PAT_OFF;
    endcase
  endfunction

  task automatic apply_register(input reg_index_t i, input logic [15:0] v);
    case (i)
      REG_OUT_MODE: begin
        led_mode = v[1:0];
        cur_pattern = PAT_NONE;
        pwm_drive = 1'b0;
      end
      REG_PINS_PRESENT: led_pins = v[1:0];
      REG_BREATH_INTERVAL: breath_ms = v[9:0];
      REG_FLASH_ON_TIME: flash_on_ms = v;
      REG_FLASH_PERIOD: flash_period_ms = v;
      default: ;
    endcase
  endtask

  task automatic predict_pins(input logic [31:0] t, input logic [3:0] rs,
                              input logic [1:0] ub, output result_t r);
    pattern_t    pat;
    logic [31:0] off_gap;
    logic [31:0] diff;
    off_gap = 32'(flash_period_ms) - 32'(flash_on_ms);
    if (led_mode == MODE_STATUS && led_pins[0]) begin
      pat = classify_state(rs);
      if (cur_pattern != pat) begin
        cur_pattern = pat;
        duty_phase = '0;
        case (pat)
          PAT_OFF: begin
            pwm_drive = 1'b0;
            lvl_one = 1'b0;
          end
          PAT_START: begin
            pwm_drive = 1'b1;
            due_ms = t + 32'(breath_ms);
          end
          PAT_RUN: begin
            pwm_drive = 1'b0;
            lvl_one = 1'b1;
          end
          PAT_COOL: begin
            pwm_drive = 1'b1;
            duty_phase = DUTY_FULL;
            due_ms = t + 32'(breath_ms);
          end
          default: begin
            pwm_drive = 1'b0;
            lvl_one = 1'b0;
            due_ms = due_ms + off_gap;
          end
        endcase
      end
      diff = t - due_ms;
      if (!diff[31]) begin
        case (pat)
          PAT_START: begin
            due_ms = due_ms + 32'(breath_ms);
            duty_phase = duty_phase + (duty_phase >> DUTY_SHIFT) + 1'b1;
          end
          PAT_COOL: begin
            due_ms = due_ms + 32'(breath_ms);
            duty_phase = duty_phase - ((duty_phase >> DUTY_SHIFT) + 1'b1);
          end
          PAT_SUSPEND: begin
            duty_phase = duty_phase + 1'b1;
            if (duty_phase[0]) begin
              due_ms = due_ms + 32'(flash_on_ms);
              lvl_one = 1'b1;
            end else begin
              due_ms = due_ms + off_gap;
              lvl_one = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end else if (led_mode == MODE_USER) begin
      if (led_pins[0]) lvl_one = ub[0];
      if (led_pins[1]) lvl_two = ub[1];
    end
    r.pwm_attached = pwm_drive;
    r.pwm_duty = pwm_drive ? duty_phase : '0;
    r.pin1_level = !pwm_drive && lvl_one;
    r.pin2_level = lvl_two;
  endtask

  task automatic write_register(input reg_index_t i, input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    apply_register(i, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_until_quiet;
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_tail != exp_head) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_item(input logic [31:0] t, input logic [3:0] rs, input logic [1:0] ub,
                           input logic typed, input result_t want);
    int      gap;
    result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 24);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    now_ms <= t;
    run_state <= rs;
    user_bits <= ub;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pins(t, rs, ub, r);
    exp_pins[exp_tail % EXP_DEPTH] = typed ? want : r;
    exp_tail++;
  endtask

  // receiver stall pattern, with a style picked at random from time to time
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_cycles == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_cycles = 50;
      end
      stall_cycles--;
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= ($urandom_range(0, 7) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic report_field(input string field, input int want, input int got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : check_out
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (exp_tail == exp_head) begin
        fail_count++;
        $display("%0t: transfer with nothing expected, got %b %0d %b %b", $time,
                 pwm_attached, pwm_duty, pin1_level, pin2_level);
      end else begin
        want = exp_pins[exp_head % EXP_DEPTH];
        exp_head++;
        if (pwm_attached !== want.pwm_attached)
          report_field("pwm_attached", int'(want.pwm_attached), int'(pwm_attached));
        if (pwm_duty !== want.pwm_duty)
          report_field("pwm_duty", int'(want.pwm_duty), int'(pwm_duty));
        if (pin1_level !== want.pin1_level)
          report_field("pin1_level", int'(want.pin1_level), int'(pin1_level));
        if (pin2_level !== want.pin2_level)
          report_field("pin2_level", int'(want.pin2_level), int'(pin2_level));
      end
    end
  end

  function automatic row_t cfg_row(input reg_index_t i, input logic [15:0] v);
    row_t w;
    w = '{default: '0};
    w.is_cfg = 1'b1;
    w.idx = i;
    w.val = v;
    return w;
  endfunction

  function automatic row_t item_row(input logic [31:0] t, input logic [3:0] rs,
                                    input logic [1:0] ub, input logic typed,
                                    input result_t want);
    row_t w;
    w = '{default: '0};
    w.t = t;
    w.rs = rs;
    w.ub = ub;
    w.typed = typed;
    w.want = want;
    return w;
  endfunction

  function automatic void add_row(input row_t w);
    plan[plan_len] = w;
    plan_len++;
  endfunction

  initial begin
    row_t        w;
    int          ri, p, k, r, span, n_items;
    logic [31:0] t_cur, t;
    logic [3:0]  rs_cur, rs;
    mode_t       mode_pick;
    logic [1:0]  pins_pick;
    logic [9:0]  interval_pick;
    logic [15:0] on_pick, period_pick;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    now_ms = '0;
    run_state = '0;
    user_bits = '0;

    led_mode = MODE_DISABLED;
    led_pins = '0;
    breath_ms = BREATH_INTERVAL_RESET;
    flash_on_ms = FLASH_ON_TIME_RESET;
    flash_period_ms = FLASH_PERIOD_RESET;
    cur_pattern = PAT_NONE;
    duty_phase = '0;
    due_ms = '0;
    pwm_drive = 1'b0;
    lvl_one = 1'b0;
    lvl_two = 1'b0;

    // disabled after reset, then user levels and unfitted pins
    add_row(item_row(32'd0, 4'd0, 2'd0, 1'b1, {1'b0, 8'd0, 1'b0, 1'b0}));
    add_row(item_row(32'hffff_ffff, 4'd15, 2'd3, 1'b1, {1'b0, 8'd0, 1'b0, 1'b0}));
    add_row(cfg_row(REG_PINS_PRESENT, 16'd3));
    add_row(cfg_row(REG_OUT_MODE, 16'(MODE_USER)));
    add_row(item_row(32'd10, 4'd0, 2'd3, 1'b1, {1'b0, 8'd0, 1'b1, 1'b1}));
    add_row(item_row(32'd11, 4'd5, 2'd0, 1'b1, {1'b0, 8'd0, 1'b0, 1'b0}));
    add_row(item_row(32'd12, 4'd0, 2'd3, 1'b1, {1'b0, 8'd0, 1'b1, 1'b1}));
    add_row(cfg_row(REG_PINS_PRESENT, 16'd2));
    add_row(item_row(32'd13, 4'd0, 2'd0, 1'b1, {1'b0, 8'd0, 1'b1, 1'b0}));
    // status mode with pin one missing
    add_row(cfg_row(REG_OUT_MODE, 16'(MODE_STATUS)));
    add_row(item_row(32'd14, 4'd1, 2'd3, 1'b1, {1'b0, 8'd0, 1'b1, 1'b0}));
    add_row(cfg_row(REG_PINS_PRESENT, 16'd1));
    // every pattern
    add_row(item_row(32'd1000, 4'd1, 2'd0, 1'b1, {1'b1, 8'd0, 1'b0, 1'b0}));
    add_row(item_row(32'd1045, 4'd2, 2'd0, 1'b0, '0));
    add_row(item_row(32'd1090, 4'd9, 2'd0, 1'b0, '0));
    add_row(item_row(32'd2000, 4'd5, 2'd0, 1'b1, {1'b0, 8'd0, 1'b1, 1'b0}));
    add_row(item_row(32'd3000, 4'd6, 2'd0, 1'b1, {1'b1, 8'd255, 1'b0, 1'b0}));
    add_row(item_row(32'd3045, 4'd12, 2'd0, 1'b0, '0));
    add_row(item_row(32'd4000, 4'd10, 2'd0, 1'b0, '0));
    add_row(item_row(32'd5040, 4'd10, 2'd0, 1'b0, '0));
    add_row(item_row(32'd5090, 4'd10, 2'd0, 1'b0, '0));
    add_row(item_row(32'd5100, 4'd0, 2'd0, 1'b1, {1'b0, 8'd0, 1'b0, 1'b0}));
    // zero breath interval, flash period below on time, wrapped deadlines
    add_row(cfg_row(REG_BREATH_INTERVAL, 16'd0));
    add_row(cfg_row(REG_FLASH_ON_TIME, 16'd65535));
    add_row(cfg_row(REG_FLASH_PERIOD, 16'd2));
    add_row(item_row(32'd100, 4'd3, 2'd0, 1'b0, '0));
    add_row(item_row(32'd100, 4'd4, 2'd0, 1'b0, '0));
    add_row(item_row(32'h8000_0000, 4'd10, 2'd0, 1'b0, '0));
    add_row(item_row(32'h7fff_ffff, 4'd10, 2'd0, 1'b0, '0));
    add_row(item_row(32'd0, 4'd10, 2'd1, 1'b0, '0));
    add_row(cfg_row(REG_BREATH_INTERVAL, 16'd1023));
    add_row(cfg_row(REG_OUT_MODE, 16'(MODE_UNUSED)));
    add_row(item_row(32'd20, 4'd7, 2'd2, 1'b0, '0));
    add_row(cfg_row(REG_OUT_MODE, 16'(MODE_STATUS)));
    add_row(item_row(32'd50, 4'd11, 2'd0, 1'b1, {1'b1, 8'd255, 1'b0, 1'b0}));
    add_row(item_row(32'd1073, 4'd11, 2'd0, 1'b0, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (ri = 0; ri < plan_len; ri++) begin
      w = plan[ri];
      if (w.is_cfg) begin
        wait_until_quiet();
        write_register(w.idx, w.val);
      end else begin
        send_item(w.t, w.rs, w.ub, w.typed, w.want);
      end
    end

    for (p = 0; p < 11; p++) begin
      wait_until_quiet();
      case (p)
        1: mode_pick = MODE_USER;
        2: mode_pick = MODE_DISABLED;
        3: mode_pick = MODE_UNUSED;
        default: begin
          r = $urandom_range(0, 9);
          mode_pick = (r == 0) ? MODE_USER : MODE_STATUS;
        end
      endcase
      r = $urandom_range(0, 7);
      pins_pick = (r == 0) ? 2'd0 : (r == 1) ? 2'd2 : {1'($urandom_range(0, 1)), 1'b1};
      case (p)
        4: interval_pick = 10'd0;
        5: interval_pick = 10'd1;
        6: interval_pick = 10'd1023;
        default: interval_pick = 10'($urandom_range(1, 60));
      endcase
      case (p)
        7: begin
          on_pick = 16'd65535;
          period_pick = 16'd65535;
        end
        8: begin
          on_pick = 16'd1;
          period_pick = 16'd2;
        end
        9: begin
          on_pick = 16'd30;
          period_pick = 16'd5;
        end
        10: begin
          on_pick = 16'd0;
          period_pick = 16'd0;
        end
        default: begin
          on_pick = 16'($urandom_range(1, 40));
          period_pick = on_pick + 16'($urandom_range(1, 80));
        end
      endcase
      write_register(REG_PINS_PRESENT, 16'(pins_pick));
      write_register(REG_BREATH_INTERVAL, 16'(interval_pick));
      write_register(REG_FLASH_ON_TIME, on_pick);
      write_register(REG_FLASH_PERIOD, period_pick);
      write_register(REG_OUT_MODE, 16'(mode_pick));

      t_cur = $urandom;
      rs_cur = 4'($urandom_range(0, 15));
      n_items = $urandom_range(100, 135);
      for (k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 5) rs_cur = 4'($urandom_range(0, 15));
        rs = rs_cur;
        if (r >= 95) begin
          // noise: time from anywhere, state random
          t = $urandom;
          rs = 4'($urandom_range(0, 15));
        end else if (r >= 90) begin
          t_cur = t_cur + $urandom_range(0, 200000);
          t = t_cur;
        end else begin
          span = $urandom_range(0, 1) ? int'(breath_ms) + 2 : 90;
          t_cur = t_cur + $urandom_range(0, span);
          t = t_cur;
        end
        send_item(t, rs, 2'($urandom_range(0, 3)), 1'b0, '0);
      end
    end

    wait_until_quiet();
    if (fail_count == 0 && exp_tail == exp_head) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
